// ===== rtl/core/mh64_pkg.sv =====
// Shared constants, operation codes and the command bundle of the MurmurHash64A block.
package mh64_pkg;

    localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
    localparam int unsigned MIX_SHIFT = 47;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_INIT   = 3'd1,
        OP_WORD_A = 3'd2,
        OP_WORD_B = 3'd3,
        OP_HASH   = 3'd4,
        OP_TAIL   = 3'd5,
        OP_FINAL  = 3'd6
    } op_t;

    typedef struct packed {
        logic capture;
        logic mul_a;
        logic mul_b;
        logic load_out;
        op_t  op;
    } cmd_t;

endpackage

// ===== rtl/core/mh64_datapath.sv =====
// Datapath: running hash, chunk registers, seed and the registered constant multiplier.
module mh64_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  mh64_pkg::cmd_t     cmd,
    input  logic               seed_write,
    input  logic [31:0]        seed_data,
    input  logic [30:0]        key_length,
    input  logic [63:0]        chunk,
    input  logic [2:0]         chunk_bytes,
    output logic [63:0]        hash
);

    localparam logic [31:0] MUL_LO = mh64_pkg::MIX_MUL[31:0];
    localparam logic [31:0] MUL_HI = mh64_pkg::MIX_MUL[63:32];

    logic [31:0] seed_reg;
    logic [63:0] h_reg;
    logic [63:0] h_next;
    logic [63:0] w_reg;
    logic [63:0] w_next;
    logic [30:0] len_reg;
    logic [2:0]  nbytes_reg;
    logic [63:0] p0_reg;
    logic [31:0] p1_reg;
    logic [31:0] p2_reg;
    logic [63:0] hash_reg;
    logic [63:0] tail_mask;
    logic [63:0] operand;
    logic [63:0] prod;
    logic [31:0] mid_sum;

    function automatic logic [63:0] mul32(input logic [31:0] x, input logic [31:0] y);
        return {32'd0, x} * {32'd0, y};
    endfunction

    function automatic logic [31:0] mul32_lo(input logic [31:0] x, input logic [31:0] y);
        return x * y;
    endfunction

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            tail_mask[i*8 +: 8] = (3'(i) < nbytes_reg) ? 8'hff : 8'h00;
        end
    end

    always_comb
    begin
        unique case (cmd.op)
            mh64_pkg::OP_INIT:   operand = {33'd0, len_reg};
            mh64_pkg::OP_WORD_A: operand = w_reg;
            mh64_pkg::OP_WORD_B: operand = w_reg;
            mh64_pkg::OP_HASH:   operand = h_reg;
            mh64_pkg::OP_TAIL:   operand = h_reg ^ (w_reg & tail_mask);
            mh64_pkg::OP_FINAL:  operand = h_reg ^ (h_reg >> mh64_pkg::MIX_SHIFT);
            default:             operand = h_reg;
        endcase
    end

    assign mid_sum = p1_reg + p2_reg;
    assign prod    = p0_reg + {mid_sum, 32'd0};

    always_comb
    begin
        h_next = h_reg;
        w_next = w_reg;
        if (cmd.capture)
        begin
            w_next = chunk;
        end
        else if (cmd.mul_b)
        begin
            unique case (cmd.op)
                mh64_pkg::OP_INIT:   h_next = {32'd0, seed_reg} ^ prod;
                mh64_pkg::OP_WORD_A: w_next = prod ^ (prod >> mh64_pkg::MIX_SHIFT);
                mh64_pkg::OP_WORD_B: h_next = h_reg ^ prod;
                mh64_pkg::OP_HASH:   h_next = prod;
                mh64_pkg::OP_TAIL:   h_next = prod;
                mh64_pkg::OP_FINAL:  h_next = prod ^ (prod >> mh64_pkg::MIX_SHIFT);
                default:             h_next = h_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 32'd0;
            h_reg    <= 64'd0;
        end
        else
        begin
            if (seed_write)
            begin
                seed_reg <= seed_data;
            end
            h_reg <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        if (cmd.capture)
        begin
            len_reg    <= key_length;
            nbytes_reg <= chunk_bytes;
        end
        if (cmd.mul_a)
        begin
            p0_reg <= mul32(operand[31:0], MUL_LO);
            p1_reg <= mul32_lo(operand[63:32], MUL_LO);
            p2_reg <= mul32_lo(operand[31:0], MUL_HI);
        end
        if (cmd.load_out)
        begin
            hash_reg <= h_reg;
        end
    end

    assign hash = hash_reg;

endmodule

// ===== rtl/core/mh64_ctrl.sv =====
// Controller: sequences the multiply operations of one chunk and runs both handshakes.
module mh64_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           key_valid,
    output logic           key_stall,
    input  logic           start_req,
    input  logic [3:0]     chunk_bytes,
    input  logic           last,
    output logic           hash_valid,
    input  logic           hash_stall,
    output mh64_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MUL_A = 4'b0010,
        ST_MUL_B = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    mh64_pkg::op_t op_reg;
    mh64_pkg::op_t op_next;
    logic          word_reg;
    logic          tail_reg;
    logic          fin_reg;
    logic          hash_valid_reg;
    logic          hash_valid_next;
    logic          accept;
    logic          in_word;
    logic          in_tail;
    mh64_pkg::op_t first_op;
    mh64_pkg::op_t after_op;

    function automatic mh64_pkg::op_t mix_op(input logic word, input logic tail,
                                             input logic fin);
        if (word)
            return mh64_pkg::OP_WORD_A;
        else if (tail)
            return mh64_pkg::OP_TAIL;
        else if (fin)
            return mh64_pkg::OP_FINAL;
        else
            return mh64_pkg::OP_NONE;
    endfunction

    assign in_word  = chunk_bytes[3];
    assign in_tail  = !chunk_bytes[3] && (chunk_bytes[2:0] != 3'd0);
    assign first_op = start_req ? mh64_pkg::OP_INIT : mix_op(in_word, in_tail, last);

    always_comb
    begin
        unique case (op_reg)
            mh64_pkg::OP_INIT:   after_op = mix_op(word_reg, tail_reg, fin_reg);
            mh64_pkg::OP_WORD_A: after_op = mh64_pkg::OP_WORD_B;
            mh64_pkg::OP_WORD_B: after_op = mh64_pkg::OP_HASH;
            mh64_pkg::OP_HASH:   after_op = fin_reg ? mh64_pkg::OP_FINAL : mh64_pkg::OP_NONE;
            mh64_pkg::OP_TAIL:   after_op = fin_reg ? mh64_pkg::OP_FINAL : mh64_pkg::OP_NONE;
            default:             after_op = mh64_pkg::OP_NONE;
        endcase
    end

    assign key_stall = (state_reg != ST_IDLE);
    assign accept    = key_valid && !key_stall;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        hash_valid_next = hash_valid_reg && hash_stall;
        cmd.capture     = accept;
        cmd.mul_a       = 1'b0;
        cmd.mul_b       = 1'b0;
        cmd.load_out    = 1'b0;
        cmd.op          = op_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (first_op != mh64_pkg::OP_NONE))
                begin
                    op_next    = first_op;
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A:
            begin
                cmd.mul_a  = 1'b1;
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                cmd.mul_b = 1'b1;
                if (op_reg == mh64_pkg::OP_FINAL)
                begin
                    state_next = ST_EMIT;
                end
                else if (after_op == mh64_pkg::OP_NONE)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    op_next    = after_op;
                    state_next = ST_MUL_A;
                end
            end
            ST_EMIT:
            begin
                if (!hash_valid_reg || !hash_stall)
                begin
                    cmd.load_out    = 1'b1;
                    hash_valid_next = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= mh64_pkg::OP_NONE;
            hash_valid_reg <= 1'b0;
            word_reg       <= 1'b0;
            tail_reg       <= 1'b0;
            fin_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            hash_valid_reg <= hash_valid_next;
            if (accept)
            begin
                word_reg <= in_word;
                tail_reg <= in_tail;
                fin_reg  <= last;
            end
        end
    end

    assign hash_valid = hash_valid_reg;

endmodule

// ===== rtl/core/murmur_hash_64a.sv =====
// Top level of the streaming MurmurHash64A block: controller plus datapath.
//
//   Channel   Handshake                Payload
//   key       key_valid / key_stall    start_req, key_length, chunk, chunk_bytes, last
//   hash      hash_valid / hash_stall  hash
//   seed      seed_valid / seed_ready  seed
//
// Every 64-bit multiply by the mixing constant runs on one shared unit (three 32x32
// partial products are registered, then one add), so a chunk runs n such multiplies
// in turn, n from 0 to 5: start adds one, a full word three, a tail one, last one more.
// A finished hash moves from the emit state into the output register once that is empty or not stalled.
// The output register waits under hash_stall while the next chunk is taken.
// Reset clears the seed and running hash to zero; seed_ready is always high.
module murmur_hash_64a (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        key_valid,
    output logic        key_stall,
    input  logic        start_req,
    input  logic [30:0] key_length,
    input  logic [63:0] chunk,
    input  logic [3:0]  chunk_bytes,
    input  logic        last,
    output logic        hash_valid,
    input  logic        hash_stall,
    output logic [63:0] hash,
    input  logic        seed_valid,
    output logic        seed_ready,
    input  logic [31:0] seed
);

    mh64_pkg::cmd_t cmd;

    assign seed_ready = 1'b1;

    mh64_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .key_valid   (key_valid),
        .key_stall   (key_stall),
        .start_req   (start_req),
        .chunk_bytes (chunk_bytes),
        .last        (last),
        .hash_valid  (hash_valid),
        .hash_stall  (hash_stall),
        .cmd         (cmd)
    );

    mh64_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .seed_write  (seed_valid && seed_ready),
        .seed_data   (seed),
        .key_length  (key_length),
        .chunk       (chunk),
        .chunk_bytes (chunk_bytes[2:0]),
        .hash        (hash)
    );

endmodule
